/* rtl/shared_buffer_multi_queue_unit_defines.svh */
// Assertion macros for the shared buffer multi-queue unit.
// Used by sbmq_ctrl and sbmq_dp; expects clk and arst_n in scope.
`ifndef SHARED_BUFFER_MULTI_QUEUE_UNIT_DEFINES_SVH
`define SHARED_BUFFER_MULTI_QUEUE_UNIT_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define SBMQ_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("sbmq: same-cycle check failed");
// next-cycle implication
`define SBMQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("sbmq: next-cycle check failed");
`else
`define SBMQ_ASSERT_IMPL(label, ante, cons)
`define SBMQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/sbmq_pkg.sv */
// Shared types, constants and helpers of the shared buffer multi-queue unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sbmq_pkg;

	localparam int ENTRIES   = 16;
	localparam int QUEUES    = 4;
	localparam int DATA_BITS = 32;
	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int QSEL_W    = 2;
	localparam int QCNT_W    = QSEL_W + 1;
	localparam int VAL_W     = 32;

	typedef enum logic {
		FUNC_PUSH = 1'b0,
		FUNC_POP  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		func_t                    func;
		logic [QSEL_W-1:0]        queue_sel;
		logic signed [VAL_W-1:0]  push_value;
	} op_t;

	typedef struct packed {
		status_t                  status;
		logic signed [VAL_W-1:0]  pop_value;
	} result_t;

	// entry pointer: index plus valid, invalid means null
	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
	} ptr_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
	} ctl_t;

	// link value of an entry that has not been rewritten since reset
	function automatic ptr_t link_reset(input logic [IDX_W-1:0] i);
		ptr_t p;
		p.vld = (int'(i) + 1) < ENTRIES;
		p.idx = i + IDX_W'(1);
		return p;
	endfunction

endpackage
`default_nettype wire

/* rtl/sbmq_ctrl.sv */
// Controller of the shared buffer multi-queue unit: load / execute sequencing.
// Depends on sbmq_pkg and shared_buffer_multi_queue_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "shared_buffer_multi_queue_unit_defines.svh"
module sbmq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	output sbmq_pkg::ctl_t     ctl
);
	import sbmq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign busy     = (state_q == S_EXEC);
	assign ctl.load = start && (state_q == S_IDLE);
	assign ctl.exec = (state_q == S_EXEC);

	`SBMQ_ASSERT_NEXT(a_load_busy, ctl.load, busy)
	`SBMQ_ASSERT_NEXT(a_exec_one_cycle, busy, !busy)

endmodule
`default_nettype wire

/* rtl/sbmq_dp.sv */
// Datapath of the shared buffer multi-queue unit: link and data stores,
// queue head/tail pointers, free list and result register.
// Depends on sbmq_pkg and shared_buffer_multi_queue_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "shared_buffer_multi_queue_unit_defines.svh"
module sbmq_dp (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sbmq_pkg::ctl_t   ctl,
	input  wire sbmq_pkg::op_t    op,
	output logic                  done,
	output sbmq_pkg::result_t     res
);
	import sbmq_pkg::*;

	// stores
	ptr_t                 link_mem [ENTRIES];
	logic [DATA_BITS-1:0] data_mem [ENTRIES];
	logic [ENTRIES-1:0]   link_wr_q;

	// pointers
	ptr_t head_q [QUEUES];
	ptr_t tail_q [QUEUES];
	ptr_t free_q;

	// item and read beat
	op_t                  item_q;
	logic [IDX_W-1:0]     rd_addr;
	logic [IDX_W-1:0]     rd_addr_s1;
	ptr_t                 link_rd_s1;
	logic                 link_wr_s1;
	logic [DATA_BITS-1:0] data_rd_s1;

	// execute
	logic                 q_ok;
	ptr_t                 link_eff;
	ptr_t                 head_cur;
	ptr_t                 tail_cur;
	logic                 push_ok;
	logic                 pop_ok;
	logic                 lwr_en;
	logic [IDX_W-1:0]     lwr_addr;
	ptr_t                 lwr_data;

	logic                 done_q;
	result_t              res_q;

	// push reads the free head, pop reads the queue head
	assign rd_addr = (op.func == FUNC_POP) ? head_q[op.queue_sel].idx : free_q.idx;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q     <= op;
			rd_addr_s1 <= rd_addr;
			link_rd_s1 <= link_mem[rd_addr];
			data_rd_s1 <= data_mem[rd_addr];
		end
		if (lwr_en) link_mem[lwr_addr] <= lwr_data;
		if (ctl.exec && push_ok) data_mem[free_q.idx] <= DATA_BITS'(item_q.push_value);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_wr_q  <= '0;
			link_wr_s1 <= 1'b0;
		end else begin
			if (ctl.load) link_wr_s1 <= link_wr_q[rd_addr];
			if (lwr_en) link_wr_q[lwr_addr] <= 1'b1;
		end
	end

	assign q_ok     = {1'b0, item_q.queue_sel} < QCNT_W'(QUEUES);
	assign link_eff = link_wr_s1 ? link_rd_s1 : link_reset(rd_addr_s1);
	assign head_cur = head_q[item_q.queue_sel];
	assign tail_cur = tail_q[item_q.queue_sel];
	assign push_ok  = (item_q.func == FUNC_PUSH) && q_ok && free_q.vld;
	assign pop_ok   = (item_q.func == FUNC_POP) && q_ok && head_cur.vld;

	// at most one link write per op: append after tail, or return entry to free list
	always_comb begin
		lwr_en   = 1'b0;
		lwr_addr = tail_cur.idx;
		lwr_data = '{vld: 1'b1, idx: free_q.idx};
		if (ctl.exec && push_ok && head_cur.vld && tail_cur.vld) begin
			lwr_en = 1'b1;
		end else if (ctl.exec && pop_ok) begin
			lwr_en   = 1'b1;
			lwr_addr = head_cur.idx;
			lwr_data = free_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			free_q <= '{vld: 1'b1, idx: '0};
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.exec;
			if (ctl.exec && push_ok) begin
				free_q <= link_eff;
				if (!head_cur.vld) head_q[item_q.queue_sel] <= '{vld: 1'b1, idx: free_q.idx};
				tail_q[item_q.queue_sel] <= '{vld: 1'b1, idx: free_q.idx};
			end
			if (ctl.exec && pop_ok) begin
				// single-entry queue: the tail's link is never kept, so empty here
				if (tail_cur.vld && (head_cur.idx == tail_cur.idx))
					head_q[item_q.queue_sel] <= '0;
				else
					head_q[item_q.queue_sel] <= link_eff;
				free_q <= '{vld: 1'b1, idx: head_cur.idx};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			if (item_q.func == FUNC_PUSH) res_q.status <= push_ok ? ST_OK : ST_OVERFLOW;
			else res_q.status <= pop_ok ? ST_OK : ST_UNDERFLOW;
			res_q.pop_value <= pop_ok ? VAL_W'(data_rd_s1) : '0;
		end
	end

	assign done = done_q;
	assign res  = res_q;

	`SBMQ_ASSERT_NEXT(a_exec_done, ctl.exec, done)
	`SBMQ_ASSERT_IMPL(a_unf_zero, done && (res.status == ST_UNDERFLOW), res.pop_value == '0)
	`SBMQ_ASSERT_IMPL(a_ovf_push, done && (res.status == ST_OVERFLOW), item_q.func == FUNC_PUSH)

endmodule
`default_nettype wire

/* rtl/shared_buffer_multi_queue_unit.sv */
// Shared buffer multi-queue unit: several FIFO queues in one linked entry store
// with a free list. Top level; depends on sbmq_pkg, sbmq_ctrl and sbmq_dp.
//
// Usage
//  - Command channel: drive op (func, queue_sel, push_value) and raise start;
//    the beat is taken at a rising edge with start high and busy low.
//  - Result channel: done is high for exactly one cycle with res (status,
//    pop_value); the beat is taken at the edge ending that cycle. There is
//    no back-pressure - the receiver must take every result.
//  - Push takes the free-list head entry and links it behind the queue tail;
//    status overflow when no entry is free. Pop unlinks the queue head, returns
//    its value and puts the entry at the front of the free list; status
//    underflow on an empty queue. pop_value is zero except on a good pop.
//  - A taken beat is registered with its store reads and executed in S_EXEC;
//    done is registered from that state. The link store is read at the
//    accepting edge, pointers and links written back in S_EXEC; busy holds
//    off new beats. A new beat may be offered in the cycle in which done is high.
//  - Reset (arst_n low, async): all queues empty, free list 0..ENTRIES-1 in
//    order. Link entries read their reset value until first written; there is
//    no clearing pass, the block is ready straight after reset.
`timescale 1ns / 1ps
`default_nettype none
module shared_buffer_multi_queue_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire sbmq_pkg::op_t op,
	output logic               done,
	output sbmq_pkg::result_t  res
);
	import sbmq_pkg::*;

	// command bundle from the sequencer to the datapath
	ctl_t ctl;

	// sequencer: idle / execute
	sbmq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctl    (ctl)
	);

	// stores, pointers, free list and result register
	sbmq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.op     (op),
		.done   (done),
		.res    (res)
	);

endmodule
`default_nettype wire

/* dv/sbmq_outcome_checker.sv */
// Result checker for the shared buffer multi-queue unit: predicts each result
// from the accepted commands and compares. Depends on sbmq_pkg.
`timescale 1ns / 1ps
module sbmq_outcome_checker
	import sbmq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic busy,
	input  op_t       op,
	input  wire logic done,
	input  result_t   res,
	output int        mismatches,
	output int        outstanding
);

	localparam int SHOWN = 10;

	// shadow of the linked store
	logic [DATA_BITS-1:0] slot_data [ENTRIES];
	ptr_t                 link_tbl  [ENTRIES];
	ptr_t                 q_head    [QUEUES];
	ptr_t                 q_tail    [QUEUES];
	ptr_t                 free_ptr;

	result_t outcome_fifo [$];
	int      fault_tally;

	function automatic ptr_t ptr_to(input int i);
		ptr_t p;
		p.vld = 1'b1;
		p.idx = IDX_W'(i);
		return p;
	endfunction

	// out-of-range index counts as null
	function automatic bit is_live(input ptr_t p);
		return p.vld && int'(p.idx) < ENTRIES;
	endfunction

	task automatic clear_store();
		for (int i = 0; i < ENTRIES; i++) begin
			slot_data[i]    = '0;
			link_tbl[i].vld = (i + 1) < ENTRIES;
			link_tbl[i].idx = IDX_W'(i + 1);
		end
		for (int i = 0; i < QUEUES; i++) begin
			q_head[i] = '0;
			q_tail[i] = '0;
		end
		free_ptr = ptr_to(0);
	endtask

	// applies one command to the shadow store, returns the result it gives
	function automatic result_t queue_op_outcome(input op_t beat);
		result_t r;
		int      q;
		int      slot;
		r = '0;
		q = int'(beat.queue_sel);
		if (beat.func == FUNC_PUSH) begin
			if (q >= QUEUES || !is_live(free_ptr)) begin
				r.status = ST_OVERFLOW;
			end else begin
				slot     = int'(free_ptr.idx);
				free_ptr = link_tbl[slot];
				if (!is_live(q_head[q])) begin
					q_head[q] = ptr_to(slot);
				end else if (is_live(q_tail[q])) begin
					link_tbl[q_tail[q].idx] = ptr_to(slot);
				end
				link_tbl[slot]  = '0;
				q_tail[q]       = ptr_to(slot);
				slot_data[slot] = DATA_BITS'($unsigned(beat.push_value));
				r.status        = ST_OK;
			end
		end else begin
			if (q >= QUEUES || !is_live(q_head[q])) begin
				r.status = ST_UNDERFLOW;
			end else begin
				slot           = int'(q_head[q].idx);
				q_head[q]      = link_tbl[slot];
				link_tbl[slot] = free_ptr;
				free_ptr       = ptr_to(slot);
				r.status       = ST_OK;
				r.pop_value    = VAL_W'(slot_data[slot]);
			end
		end
		return r;
	endfunction

	task automatic note_fault(input string what, input result_t want, input result_t got);
		fault_tally++;
		if (fault_tally <= SHOWN)
			$display("%0t %m: %s: expected status %0d value %h, got status %0d value %h",
				$time, what, want.status, want.pop_value, got.status, got.pop_value);
	endtask

	// a result beat seen at an edge belongs to an earlier command, so it is
	// checked before any command taken at the same edge is predicted
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			clear_store();
			outcome_fifo.delete();
			fault_tally = 0;
		end else begin
			if (done) begin
				if (outcome_fifo.size() == 0) begin
					note_fault("result beat with nothing outstanding", '0, res);
				end else begin
					want = outcome_fifo.pop_front();
					if (res.status !== want.status)
						note_fault("status mismatch", want, res);
					if (res.pop_value !== want.pop_value)
						note_fault("pop_value mismatch", want, res);
				end
			end
			if (start && !busy)
				outcome_fifo.push_back(queue_op_outcome(op));
		end
		mismatches  <= fault_tally;
		outstanding <= outcome_fifo.size();
	end

endmodule

/* dv/tb_shared_buffer_multi_queue_unit.sv */
// Testbench top for the shared buffer multi-queue unit: drives command beats
// and gives the verdict. Depends on sbmq_pkg, sbmq_outcome_checker and the RTL.
`timescale 1ns / 1ps
module tb_shared_buffer_multi_queue_unit;
	import sbmq_pkg::*;

	// limit set many times above the length of the slowest run
	localparam int LIMIT        = 200000;
	localparam int RANDOM_BEATS = 1225;
	localparam int SETTLE       = 8;

	logic    clk;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	op_t     op     = '0;
	logic    busy;
	logic    done;
	result_t res;

	int mismatches;
	int outstanding;
	int cycle_count = 0;
	int idle_pct    = 0;

	shared_buffer_multi_queue_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.op     (op),
		.done   (done),
		.res    (res)
	);

	sbmq_outcome_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.done        (done),
		.res         (res),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog: a hung handshake or a lost result ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("tb_shared_buffer_multi_queue_unit: errors");
			$finish;
		end
	end

	// Offers one command beat and returns at the edge that takes it.
	// An optional idle gap comes first; with no gap start simply stays high,
	// so start is never lowered and raised within one step.
	task automatic issue(input func_t f, input logic [QSEL_W-1:0] q,
			input logic [VAL_W-1:0] v);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start        <= 1'b1;
		op.func       <= f;
		op.queue_sel  <= q;
		op.push_value <= v;
		// busy is sampled before the edge's updates land, so this is the
		// same view the block has
		do @(posedge clk); while (busy);
	endtask

	// extremes turn up often, the rest is full-width noise
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return '0;
			3:       return '1;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	initial begin
		int                sent;
		int                seg_len;
		int                push_pct;
		int                focus;
		bit                focused;
		logic [QSEL_W-1:0] q;
		func_t             f;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part, back to back ---
		// pops from empty queues
		issue(FUNC_POP,  2'd0, '0);
		issue(FUNC_POP,  2'd3, '1);
		// value extremes through different queues
		issue(FUNC_PUSH, 2'd0, 32'h7FFF_FFFF);
		issue(FUNC_PUSH, 2'd1, 32'h8000_0000);
		issue(FUNC_PUSH, 2'd2, 32'h0000_0000);
		issue(FUNC_PUSH, 2'd3, 32'hFFFF_FFFF);
		issue(FUNC_PUSH, 2'd0, 32'h5555_5555);
		// FIFO order within a queue, then drain one to empty
		issue(FUNC_POP,  2'd0, '0);
		issue(FUNC_POP,  2'd1, '0);
		issue(FUNC_POP,  2'd1, '0);
		// three entries in use: fill the remaining thirteen
		for (int i = 0; i < 13; i++)
			issue(FUNC_PUSH, QSEL_W'(i), 32'hA5A5_0000 | i);
		// store full, then free one entry
		issue(FUNC_PUSH, 2'd1, 32'h1234_5678);
		issue(FUNC_POP,  2'd2, '0);

		// --- random part ---
		// segments lean towards push or pop so the store swings between
		// full and empty; some segments crowd one queue to build long chains
		sent = 0;
		while (sent < RANDOM_BEATS) begin
			seg_len = $urandom_range(20, 60);
			case ($urandom_range(0, 2))
				0:       push_pct = 15;
				1:       push_pct = 50;
				default: push_pct = 85;
			endcase
			focus   = $urandom_range(0, QUEUES - 1);
			focused = $urandom_range(0, 1);
			// idle phases: none, heavy, light
			case ((sent / 150) % 3)
				0:       idle_pct = 0;
				1:       idle_pct = 45;
				default: idle_pct = 16;
			endcase
			for (int k = 0; k < seg_len; k++) begin
				if (focused && $urandom_range(0, 99) < 70)
					q = QSEL_W'(focus);
				else
					q = QSEL_W'($urandom_range(0, 3));
				f = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
				// pop carries a random payload too, which the block must ignore
				issue(f, q, pick_value());
				sent++;
			end
		end

		// --- drain ---
		start <= 1'b0;
		// one edge so the last taken beat shows in the outstanding count
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("tb_shared_buffer_multi_queue_unit: clean");
		else
			$display("tb_shared_buffer_multi_queue_unit: errors");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/sbmq_pkg.sv
rtl/sbmq_ctrl.sv
rtl/sbmq_dp.sv
rtl/shared_buffer_multi_queue_unit.sv
dv/sbmq_outcome_checker.sv
dv/tb_shared_buffer_multi_queue_unit.sv
